// File: hw/rtl/npcs_pkg.sv
`default_nettype none

package npcs_pkg;

    localparam int CHAN_W  = 8;
    localparam int INDEX_W = 8;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int WGT_W   = 10;
    localparam int PROD_W  = WGT_W + SQ_W;
    localparam int TERM_W  = PROD_W - 8;
    localparam int DIST_W  = 20;

    localparam int RED_WGT_BASE  = 512;
    localparam int BLUE_WGT_BASE = 767;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic               vld;
        logic [INDEX_W-1:0] idx;
        logic [DIST_W-1:0]  distance;
    } dist_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/npcs_req_if.sv
`default_nettype none

interface npcs_req_if;
    import npcs_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [INDEX_W-1:0] entry_index;
    logic [CHAN_W-1:0]  red_value;
    logic [CHAN_W-1:0]  green_value;
    logic [CHAN_W-1:0]  blue_value;

    modport source (
        output valid,
        output req_type,
        output entry_index,
        output red_value,
        output green_value,
        output blue_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  entry_index,
        input  red_value,
        input  green_value,
        input  blue_value,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/npcs_res_if.sv
`default_nettype none

interface npcs_res_if;
    import npcs_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] best_index;

    modport source (
        output valid,
        output best_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  best_index,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/npcs_pal_mem.sv
`default_nettype none

module npcs_pal_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire npcs_pkg::color_t    wr_data,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output npcs_pkg::color_t         rd_data
);
    import npcs_pkg::*;

    color_t palette_mem [DEPTH];
    color_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            palette_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= palette_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

`default_nettype wire

// File: hw/rtl/npcs_dist_pipe.sv
`default_nettype none

module npcs_dist_pipe (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_vld,
    input  wire logic [npcs_pkg::INDEX_W-1:0] in_idx,
    input  wire npcs_pkg::color_t             entry_color,
    input  wire npcs_pkg::color_t             query_color,
    output npcs_pkg::dist_res_t               res
);
    import npcs_pkg::*;

    // stage 1: channel differences squared, red mean
    logic [CHAN_W-1:0]  dr, dg, db;
    logic [CHAN_W:0]    rsum;
    logic               s1_vld_reg;
    logic [INDEX_W-1:0] s1_idx_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [CHAN_W-1:0]  rmean_reg;

    // stage 2: weighted terms
    logic [WGT_W-1:0]   rwgt, bwgt;
    logic [PROD_W-1:0]  rprod, bprod;
    logic               s2_vld_reg;
    logic [INDEX_W-1:0] s2_idx_reg;
    logic [TERM_W-1:0]  rterm_reg, gterm_reg, bterm_reg;

    // stage 3: sum
    logic               s3_vld_reg;
    logic [INDEX_W-1:0] s3_idx_reg;
    logic [DIST_W-1:0]  dist_reg;

    always_comb
    begin
        dr = (query_color.red >= entry_color.red) ?
             query_color.red - entry_color.red : entry_color.red - query_color.red;
        dg = (query_color.green >= entry_color.green) ?
             query_color.green - entry_color.green : entry_color.green - query_color.green;
        db = (query_color.blue >= entry_color.blue) ?
             query_color.blue - entry_color.blue : entry_color.blue - query_color.blue;
        rsum = {1'b0, query_color.red} + {1'b0, entry_color.red};
        rwgt = WGT_W'(RED_WGT_BASE) + WGT_W'(rmean_reg);
        bwgt = WGT_W'(BLUE_WGT_BASE) - WGT_W'(rmean_reg);
        rprod = PROD_W'(rwgt) * PROD_W'(sq_r_reg);
        bprod = PROD_W'(bwgt) * PROD_W'(sq_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= in_idx;
        sq_r_reg   <= SQ_W'(dr) * SQ_W'(dr);
        sq_g_reg   <= SQ_W'(dg) * SQ_W'(dg);
        sq_b_reg   <= SQ_W'(db) * SQ_W'(db);
        rmean_reg  <= rsum[CHAN_W:1];

        s2_idx_reg <= s1_idx_reg;
        rterm_reg  <= rprod[PROD_W-1:8];
        gterm_reg  <= {sq_g_reg, 2'b00};
        bterm_reg  <= bprod[PROD_W-1:8];

        s3_idx_reg <= s2_idx_reg;
        dist_reg   <= DIST_W'(rterm_reg) + DIST_W'(gterm_reg) + DIST_W'(bterm_reg);
    end

    assign res.vld      = s3_vld_reg;
    assign res.idx      = s3_idx_reg;
    assign res.distance = dist_reg;
endmodule

`default_nettype wire

// File: hw/rtl/nearest_palette_color_search_core.sv
// Palette write: one transaction per cycle while no query is in progress, no result.
// Query: N = PALETTE_ENTRIES palette reads, one per cycle from the single read port,
// through a three-stage distance pipeline; the best index is registered as the result
// once the previous result has been taken, and ready returns as the result is registered.
// Reset (rst_n, asynchronous, active low) clears control only; palette contents are
// undefined until written.
`default_nettype none

module nearest_palette_color_search_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    npcs_req_if.sink   req,
    npcs_res_if.source res
);
    import npcs_pkg::*;

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);
    localparam logic [INDEX_W-1:0] LAST_IDX  = INDEX_W'(PALETTE_ENTRIES - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t             state_reg;
    logic               issuing_reg;
    logic [ADDR_W-1:0]  issue_cnt_reg;
    logic               rd_vld_reg;
    logic [INDEX_W-1:0] rd_idx_reg;
    color_t             query_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [INDEX_W-1:0] best_idx_reg;
    logic               res_vld_reg;
    logic [INDEX_W-1:0] res_idx_reg;

    logic      accept;
    logic      wr_en;
    logic      issue;
    logic      res_free;
    color_t    req_color;
    color_t    entry_color;
    dist_res_t dres;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign req_color = '{red: req.red_value, green: req.green_value, blue: req.blue_value};
    assign wr_en     = accept && (req.req_type == REQ_WRITE) &&
                       ({1'b0, req.entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));
    assign issue     = (state_reg == ST_SCAN) && issuing_reg;
    assign res_free  = !res_vld_reg || res.ready;

    npcs_pal_mem #(
        .DEPTH  (PALETTE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (req.entry_index[ADDR_W-1:0]),
        .wr_data (req_color),
        .rd_en   (issue),
        .rd_addr (issue_cnt_reg),
        .rd_data (entry_color)
    );

    npcs_dist_pipe u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (rd_vld_reg),
        .in_idx      (rd_idx_reg),
        .entry_color (entry_color),
        .query_color (query_reg),
        .res         (dres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            issuing_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= issue;
            rd_idx_reg <= INDEX_W'(issue_cnt_reg);
            if (res.valid && res.ready && (state_reg != ST_DONE))
            begin
                res_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (req.req_type == REQ_QUERY))
                    begin
                        query_reg     <= req_color;
                        issue_cnt_reg <= '0;
                        issuing_reg   <= 1'b1;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        if (issue_cnt_reg == LAST_ADDR)
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_cnt_reg <= issue_cnt_reg + 1'b1;
                        end
                    end
                    if (dres.vld)
                    begin
                        // strict compare keeps the lowest index on ties
                        if ((dres.idx == '0) || (dres.distance < best_dist_reg))
                        begin
                            best_dist_reg <= dres.distance;
                            best_idx_reg  <= dres.idx;
                        end
                        if (dres.idx == LAST_IDX)
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (res_free)
                    begin
                        res_vld_reg <= 1'b1;
                        res_idx_reg <= best_idx_reg;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        res_vld_reg <= res_vld_reg;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res.valid      = res_vld_reg;
    assign res.best_index = res_idx_reg;
endmodule

`default_nettype wire
